// ===== rtl/core/asgr_pkg.sv =====
// ---------------------------------------------------------------------------
// asgr_pkg
// Shared types and character codes for the ANSI SGR terminal parser.
// ---------------------------------------------------------------------------
package asgr_pkg;

  localparam int CELL_W = 11;

  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_M      = 8'h6D;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;

  localparam logic [7:0] SGR_FG_LO = 8'd30;
  localparam logic [7:0] SGR_FG_HI = 8'd37;
  localparam logic [7:0] SGR_BG_LO = 8'd40;
  localparam logic [7:0] SGR_BG_HI = 8'd47;
  localparam logic [7:0] ACC_MAX   = 8'd255;

  localparam logic [2:0] FG_DEFAULT = 3'd7;
  localparam logic [2:0] BG_DEFAULT = 3'd0;

  typedef enum logic [1:0] {
    PH_TEXT  = 2'd0,
    PH_ESC   = 2'd1,
    PH_PARAM = 2'd2
  } phase_t;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SCROLL = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t              kind;
    logic [CELL_W-1:0] cell_idx;
    logic [7:0]        glyph;
    logic [2:0]        fg;
    logic [2:0]        bg;
    logic              last;
  } result_t;

endpackage

// ===== rtl/core/asgr_parse.sv =====
// ---------------------------------------------------------------------------
// asgr_parse
// Escape parser, colour and cursor state; decodes one byte into up to two
// grid commands and updates the state when the byte is consumed.
// ---------------------------------------------------------------------------
module asgr_parse
  import asgr_pkg::*;
#(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] data_byte,
  output logic [1:0] res_cnt,
  output result_t    res0,
  output result_t    res1
);

  localparam int CUR_W = $clog2(ROWS * COLS + 1);
  localparam int COL_W = $clog2(COLS);
  localparam logic [CUR_W:0]   LIMIT_X = (CUR_W + 1)'(ROWS * COLS);
  localparam logic [CUR_W-1:0] LIMIT   = CUR_W'(ROWS * COLS);
  localparam logic [CUR_W-1:0] BOT     = CUR_W'((ROWS - 1) * COLS);
  localparam logic [CUR_W:0]   COLS_X  = (CUR_W + 1)'(COLS);
  localparam logic [COL_W-1:0] COL_END = COL_W'(COLS - 1);

  phase_t           phase_r, phase_nxt;
  logic [7:0]       accum_r, accum_nxt;
  logic [2:0]       fg_r, fg_nxt;
  logic [2:0]       bg_r, bg_nxt;
  logic [CUR_W-1:0] cursor_r, cursor_nxt;
  logic [COL_W-1:0] col_r, col_nxt;

  logic             is_text;
  logic             is_digit;
  logic [11:0]      acc_prod;
  logic [7:0]       acc_sat;
  logic [CUR_W-1:0] row_start;
  logic [CUR_W:0]   lf_cursor;
  logic             lf_scroll;
  logic             past_end;
  logic [CUR_W-1:0] wr_idx;
  logic [COL_W-1:0] wr_col;
  logic [7:0]       fg_off;
  logic [7:0]       bg_off;

  // byte is handled as text after a plain ESC or in normal phase
  always_comb begin
    unique case (phase_r)
      PH_ESC:   is_text = (data_byte != CH_LBRACK);
      PH_PARAM: is_text = 1'b0;
      default:  is_text = 1'b1;
    endcase
  end

  assign is_digit  = (data_byte >= CH_0) && (data_byte <= CH_9);
  assign acc_prod  = {4'b0, accum_r} * 12'd10 + {8'b0, data_byte[3:0]};
  assign acc_sat   = (acc_prod > {4'b0, ACC_MAX}) ? ACC_MAX : acc_prod[7:0];
  assign fg_off    = accum_r - SGR_FG_LO;
  assign bg_off    = accum_r - SGR_BG_LO;

  assign row_start = cursor_r - CUR_W'(col_r);
  assign lf_cursor = {1'b0, row_start} + COLS_X;
  assign lf_scroll = (lf_cursor >= LIMIT_X);
  assign past_end  = (cursor_r >= LIMIT);
  assign wr_idx    = past_end ? BOT : cursor_r;
  assign wr_col    = past_end ? '0 : col_r;

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    accum_nxt  = accum_r;
    fg_nxt     = fg_r;
    bg_nxt     = bg_r;
    cursor_nxt = cursor_r;
    col_nxt    = col_r;
    if (is_text) begin
      phase_nxt = PH_TEXT;
      if (data_byte == CH_ESC) begin
        phase_nxt = PH_ESC;
      end else if (data_byte == CH_CR) begin
        cursor_nxt = row_start;
        col_nxt    = '0;
      end else if (data_byte == CH_LF) begin
        cursor_nxt = lf_scroll ? BOT : lf_cursor[CUR_W-1:0];
        col_nxt    = '0;
      end else begin
        cursor_nxt = wr_idx + CUR_W'(1);
        col_nxt    = (wr_col == COL_END) ? '0 : wr_col + COL_W'(1);
      end
    end else if (phase_r == PH_ESC) begin
      phase_nxt = PH_PARAM;
      accum_nxt = '0;
    end else if (is_digit) begin
      accum_nxt = acc_sat;
    end else begin
      phase_nxt = PH_TEXT;
      if (data_byte == CH_M) begin
        if (accum_r == 8'd0) begin
          fg_nxt = FG_DEFAULT;
          bg_nxt = BG_DEFAULT;
        end else if (accum_r >= SGR_FG_LO && accum_r <= SGR_FG_HI) begin
          fg_nxt = fg_off[2:0];
        end else if (accum_r >= SGR_BG_LO && accum_r <= SGR_BG_HI) begin
          bg_nxt = bg_off[2:0];
        end
      end
    end
  end

  // result decode
  always_comb begin
    result_t scr;
    result_t wr;
    scr          = '0;
    scr.kind     = CMD_SCROLL;
    wr.kind      = CMD_WRITE;
    wr.cell_idx  = CELL_W'(wr_idx);
    wr.glyph     = data_byte;
    wr.fg        = fg_r;
    wr.bg        = bg_r;
    wr.last      = 1'b1;
    res_cnt      = 2'd0;
    res0         = wr;
    res1         = wr;
    if (is_text && data_byte != CH_ESC && data_byte != CH_CR) begin
      if (data_byte == CH_LF) begin
        if (lf_scroll) begin
          res_cnt   = 2'd1;
          res0      = scr;
          res0.last = 1'b1;
        end
      end else if (past_end) begin
        res_cnt = 2'd2;
        res0    = scr;
      end else begin
        res_cnt = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TEXT;
      accum_r  <= '0;
      fg_r     <= FG_DEFAULT;
      bg_r     <= BG_DEFAULT;
      cursor_r <= '0;
      col_r    <= '0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      accum_r  <= accum_nxt;
      fg_r     <= fg_nxt;
      bg_r     <= bg_nxt;
      cursor_r <= cursor_nxt;
      col_r    <= col_nxt;
    end
  end

endmodule

// ===== rtl/core/asgr_outq.sv =====
// ---------------------------------------------------------------------------
// asgr_outq
// Two-entry result queue; takes up to two results a cycle, gives one.
// ---------------------------------------------------------------------------
module asgr_outq
  import asgr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic [1:0] push_cnt,
  input  result_t    push0,
  input  result_t    push1,
  output logic [1:0] room,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    out_res
);

  result_t    mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;
  logic [1:0] add;

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;
  assign room      = 2'd2 - cnt_r + {1'b0, pop};
  assign add       = push ? push_cnt : 2'd0;
  assign cnt_nxt   = cnt_r + add - {1'b0, pop};
  assign wp_nxt    = wp_r + add[0];
  assign rp_nxt    = rp_r + pop;
  assign out_res   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && add != 2'd0) begin
      mem_r[wp_r] <= push0;
    end
    if (push && add == 2'd2) begin
      mem_r[~wp_r] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/ansi_sgr_text_terminal_parser_top.sv =====
// ---------------------------------------------------------------------------
// ansi_sgr_text_terminal_parser_top
// Byte-stream terminal parser emitting cell-write and scroll commands.
// ---------------------------------------------------------------------------
// Usage:
//   in_* carries one stream byte per request (valid/ready). out_* carries
//   grid commands: a cell write (glyph, colours, cell index) or a scroll of
//   the grid by one row. out_last_of_run marks the final command of a byte.
//   A byte is captured into an input register, decoded there by the parser
//   against the cursor, colour and escape state, and its commands go into a
//   two-entry result queue driving the out_ port.
//   Throughput: one byte per cycle while the queue has room. A byte that
//   scrolls and writes leaves one extra command queued; while that backlog
//   stands, a later scroll-and-write byte waits in the input register.
//   ESC, CR, parameter digits and SGR bytes produce no command.
//   When out_ready is low the queue fills, the input register holds its byte
//   and in_ready drops until room frees up.
//   Reset (rst_n low, synchronous) empties both stages, puts the cursor at
//   cell 0, colours to foreground 7 / background 0, parser to plain text.
// ---------------------------------------------------------------------------
module ansi_sgr_text_terminal_parser_top
  import asgr_pkg::*;
#(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_command_kind,
  output logic [CELL_W-1:0] out_cell_index,
  output logic [7:0]        out_glyph,
  output logic [2:0]        out_fore_colour,
  output logic [2:0]        out_back_colour,
  output logic              out_last_of_run
);

  logic       vld_r;
  logic [7:0] byte_r;
  logic       fire;
  logic [1:0] res_cnt;
  logic [1:0] room;
  result_t    res0;
  result_t    res1;
  result_t    out_res;

  // byte leaves the input register once the queue can hold all its results
  assign fire     = vld_r && (res_cnt <= room);
  assign in_ready = !vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_data_byte;
    end
  end

  asgr_parse #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .data_byte (byte_r),
    .res_cnt   (res_cnt),
    .res0      (res0),
    .res1      (res1)
  );

  asgr_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire),
    .push_cnt  (res_cnt),
    .push0     (res0),
    .push1     (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_command_kind = out_res.kind;
  assign out_cell_index   = out_res.cell_idx;
  assign out_glyph        = out_res.glyph;
  assign out_fore_colour  = out_res.fg;
  assign out_back_colour  = out_res.bg;
  assign out_last_of_run  = out_res.last;

endmodule
